>>> hdl/dqs_pkg.sv
// Shared types and codes for the double-ended queue with search.
package dqs_pkg;

   typedef logic signed [31:0] value_type;
   typedef logic [2:0]         op_code_type;
   typedef logic [1:0]         status_type;

   localparam op_code_type OP_PUSH_BACK  = 3'd0;
   localparam op_code_type OP_PUSH_FRONT = 3'd1;
   localparam op_code_type OP_POP_BACK   = 3'd2;
   localparam op_code_type OP_POP_FRONT  = 3'd3;
   localparam op_code_type OP_QUERY      = 3'd4;

   localparam status_type STATUS_OK        = 2'd0;
   localparam status_type STATUS_UNDERFLOW = 2'd1;
   localparam status_type STATUS_OVERFLOW  = 2'd2;

   typedef enum logic [2:0] {
      CELL_IDLE,
      CELL_PUSH_BACK,
      CELL_PUSH_FRONT,
      CELL_POP_BACK,
      CELL_POP_FRONT,
      CELL_QUERY,
      CELL_DRAIN
   } cell_op_type;

   typedef struct packed {
      cell_op_type op;
      value_type   value;
   } cell_cmd_type;

   typedef struct packed {
      logic      valid;
      value_type data;
   } link_type;

   typedef struct packed {
      logic      hit;
      value_type res;
   } gather_type;

endpackage

>>> hdl/dqs_cell.sv
// One queue slot: holds an entry, shifts with its neighbors, gathers results toward the front.
module dqs_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  dqs_pkg::cell_cmd_type cmd,
   input  dqs_pkg::link_type    left,
   input  dqs_pkg::link_type    right,
   input  dqs_pkg::gather_type  right_gather,
   output dqs_pkg::link_type    slot,
   output dqs_pkg::gather_type  gather
);
   import dqs_pkg::*;

   logic       valid_ff;
   value_type  data_ff;
   logic       hit_ff;
   value_type  res_ff;
   logic       is_back;

   assign is_back = valid_ff & ~right.valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         unique case (cmd.op)
            CELL_PUSH_BACK: begin
               if (left.valid & ~valid_ff) valid_ff <= 1'b1;
            end
            CELL_PUSH_FRONT: valid_ff <= left.valid;
            CELL_POP_BACK: begin
               if (is_back) valid_ff <= 1'b0;
            end
            CELL_POP_FRONT: valid_ff <= right.valid;
            CELL_IDLE, CELL_QUERY, CELL_DRAIN: valid_ff <= valid_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         CELL_PUSH_BACK: begin
            if (left.valid & ~valid_ff) data_ff <= cmd.value;
         end
         CELL_PUSH_FRONT: data_ff <= left.data;
         CELL_POP_FRONT:  data_ff <= right.data;
         CELL_IDLE, CELL_POP_BACK, CELL_QUERY, CELL_DRAIN: data_ff <= data_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      unique case (cmd.op)
         CELL_IDLE: begin
            res_ff <= res_ff;
            hit_ff <= hit_ff;
         end
         CELL_DRAIN: begin
            res_ff <= res_ff | right_gather.res;
            hit_ff <= hit_ff | right_gather.hit;
         end
         CELL_POP_BACK: begin
            res_ff <= is_back ? data_ff : '0;
            hit_ff <= 1'b0;
         end
         CELL_QUERY: begin
            res_ff <= '0;
            hit_ff <= valid_ff & (data_ff == cmd.value);
         end
         CELL_PUSH_BACK, CELL_PUSH_FRONT, CELL_POP_FRONT: begin
            res_ff <= '0;
            hit_ff <= 1'b0;
         end
      endcase
   end

   assign slot.valid  = valid_ff;
   assign slot.data   = data_ff;
   assign gather.hit  = hit_ff;
   assign gather.res  = res_ff;

endmodule

>>> hdl/double_ended_queue_with_search_top.sv
// Top level of the double-ended queue with search: cell row, control and result register.
// Entries sit left-justified in a row of DEPTH cells, front in cell 0. Push back, push front
// and pop front update the cells and the output register at once; another request may be
// taken in the next cycle unless rsp_stall holds the response. Pop back and the membership
// query load a partial result into every cell at once; the results then travel one cell a
// cycle toward cell 0 and are registered once they reach it and the output register is free.
// Pops on an empty queue and pushes into a full one are reported at once and leave the queue
// unchanged. No request is taken while a slow operation runs or rsp_stall holds a result.
module double_ended_queue_with_search_top #(
   parameter int DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  dqs_pkg::op_code_type                req_op,
   input  dqs_pkg::value_type                  req_value,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output dqs_pkg::value_type                  rsp_result_value,
   output logic                                rsp_found,
   output logic [$clog2(DEPTH+1)-1:0]          rsp_entry_count,
   output logic                                rsp_is_empty,
   output dqs_pkg::status_type                 rsp_status
);
   import dqs_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int DW = $clog2(DEPTH);
   localparam logic [CW-1:0] FULL_COUNT  = CW'(DEPTH);
   localparam logic [DW-1:0] DRAIN_STEPS = DW'(DEPTH - 1);

   typedef enum logic {ST_IDLE, ST_DRAIN} state_type;

   state_type        state_ff;
   logic [CW-1:0]    count_ff;
   logic [CW-1:0]    count_in;
   logic [DW-1:0]    drain_ff;
   logic             query_ff;
   logic             rsp_valid_ff;
   value_type        rsp_result_value_ff;
   logic             rsp_found_ff;
   logic [CW-1:0]    rsp_entry_count_ff;
   logic             rsp_is_empty_ff;
   status_type       rsp_status_ff;

   logic             take;
   logic             slow;
   logic             finish;
   status_type       status_in;
   value_type        result_in;
   cell_op_type      accept_op;
   cell_cmd_type     cmd;
   link_type         head;
   link_type         tail;
   gather_type       tail_gather;
   link_type         slot [DEPTH];
   gather_type       gather [DEPTH];

   assign req_stall = (state_ff != ST_IDLE) | (rsp_valid_ff & rsp_stall);
   assign take      = req_valid & ~req_stall;
   assign finish    = (state_ff == ST_DRAIN) && (drain_ff == '0) &&
                      (~rsp_valid_ff | ~rsp_stall);

   always_comb begin
      accept_op = CELL_IDLE;
      count_in  = count_ff;
      status_in = STATUS_OK;
      result_in = '0;
      slow      = 1'b0;
      unique case (req_op)
         OP_PUSH_BACK, OP_PUSH_FRONT: begin
            if (count_ff == FULL_COUNT) begin
               status_in = STATUS_OVERFLOW;
            end else begin
               accept_op = (req_op == OP_PUSH_BACK) ? CELL_PUSH_BACK : CELL_PUSH_FRONT;
               count_in  = count_ff + 1'b1;
            end
         end
         OP_POP_BACK: begin
            if (count_ff == '0) begin
               status_in = STATUS_UNDERFLOW;
            end else begin
               accept_op = CELL_POP_BACK;
               count_in  = count_ff - 1'b1;
               slow      = 1'b1;
            end
         end
         OP_POP_FRONT: begin
            if (count_ff == '0) begin
               status_in = STATUS_UNDERFLOW;
            end else begin
               accept_op = CELL_POP_FRONT;
               count_in  = count_ff - 1'b1;
               result_in = slot[0].data;
            end
         end
         OP_QUERY: begin
            accept_op = CELL_QUERY;
            slow      = 1'b1;
         end
         default: begin
            accept_op = CELL_IDLE;
         end
      endcase
   end

   always_comb begin
      cmd.value = req_value;
      if (take) begin
         cmd.op = accept_op;
      end else if ((state_ff == ST_DRAIN) && (drain_ff != '0)) begin
         cmd.op = CELL_DRAIN;
      end else begin
         cmd.op = CELL_IDLE;
      end
   end

   assign head.valid        = 1'b1;
   assign head.data         = req_value;
   assign tail.valid        = 1'b0;
   assign tail.data         = '0;
   assign tail_gather.hit   = 1'b0;
   assign tail_gather.res   = '0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      link_type   left_link;
      link_type   right_link;
      gather_type right_g;
      if (i == 0) begin : g_first
         assign left_link = head;
      end else begin : g_mid_l
         assign left_link = slot[i-1];
      end
      if (i == DEPTH - 1) begin : g_last
         assign right_link = tail;
         assign right_g    = tail_gather;
      end else begin : g_mid_r
         assign right_link = slot[i+1];
         assign right_g    = gather[i+1];
      end
      dqs_cell u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .left         (left_link),
         .right        (right_link),
         .right_gather (right_g),
         .slot         (slot[i]),
         .gather       (gather[i])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         drain_ff     <= '0;
         query_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff & ~rsp_stall) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (take) begin
                  count_ff <= count_in;
                  if (slow) begin
                     state_ff <= ST_DRAIN;
                     drain_ff <= DRAIN_STEPS;
                     query_ff <= (req_op == OP_QUERY);
                  end else begin
                     rsp_valid_ff        <= 1'b1;
                     rsp_result_value_ff <= result_in;
                     rsp_found_ff        <= 1'b0;
                     rsp_entry_count_ff  <= count_in;
                     rsp_is_empty_ff     <= (count_in == '0);
                     rsp_status_ff       <= status_in;
                  end
               end
            end
            ST_DRAIN: begin
               if (drain_ff != '0) drain_ff <= drain_ff - 1'b1;
               if (finish) begin
                  state_ff            <= ST_IDLE;
                  rsp_valid_ff        <= 1'b1;
                  rsp_result_value_ff <= query_ff ? '0 : gather[0].res;
                  rsp_found_ff        <= query_ff & gather[0].hit;
                  rsp_entry_count_ff  <= count_ff;
                  rsp_is_empty_ff     <= (count_ff == '0);
                  rsp_status_ff       <= STATUS_OK;
               end
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_result_value = rsp_result_value_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_entry_count  = rsp_entry_count_ff;
   assign rsp_is_empty     = rsp_is_empty_ff;
   assign rsp_status       = rsp_status_ff;

endmodule
